>>> sv/text_command_line_decoder_assert.svh
// assertion macros for the checker file of the text command line decoder
`ifndef TEXT_COMMAND_LINE_DECODER_ASSERT_SVH
`define TEXT_COMMAND_LINE_DECODER_ASSERT_SVH

// property that must hold in the same cycle as its antecedent
`define TCLD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcld: same-cycle check failed");

// property that must hold in the cycle after its antecedent
`define TCLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcld: next-cycle check failed");

`endif

>>> sv/tcld_pkg.sv
// ----------------------------------------------------------------------------
// tcld_pkg
// Types and constants of the text command line decoder: the command forms,
// the command kinds and the structs passed between the units.
// ----------------------------------------------------------------------------
package tcld_pkg;

    localparam int FORM_COUNT = 7;
    localparam int PREFIX_LEN = 7;

    typedef logic [7:0] char_t;
    typedef logic [2:0] form_idx_t;

    // bit positions of the forms in the alive mask, in priority order
    localparam form_idx_t FORM_SCALE_F = 3'd0;
    localparam form_idx_t FORM_SCALE_C = 3'd1;
    localparam form_idx_t FORM_PERIOD  = 3'd2;
    localparam form_idx_t FORM_STOP    = 3'd3;
    localparam form_idx_t FORM_START   = 3'd4;
    localparam form_idx_t FORM_LOG     = 3'd5;
    localparam form_idx_t FORM_OFF     = 3'd6;

    // text of each form, padded with zero bytes
    localparam char_t FORM_TEXT [FORM_COUNT][8] = '{
        '{"S", "C", "A", "L", "E", "=", "F", 8'h00},
        '{"S", "C", "A", "L", "E", "=", "C", 8'h00},
        '{"P", "E", "R", "I", "O", "D", "=", 8'h00},
        '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "T", "A", "R", "T", 8'h00, 8'h00, 8'h00},
        '{"L", "O", "G", " ", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] FORM_LEN [FORM_COUNT] = '{
        4'd7, 4'd7, 4'd7, 4'd4, 4'd5, 4'd4, 4'd3
    };

    // forms that must match the whole line, not just its start
    localparam logic [FORM_COUNT-1:0] FORM_EXACT = 7'b1011011;

    localparam char_t CHAR_NL  = 8'h0A;
    localparam char_t CHAR_NUL = 8'h00;
    localparam char_t CHAR_0   = "0";
    localparam char_t CHAR_9   = "9";

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_SCALE_F,
        KIND_SCALE_C,
        KIND_PERIOD,
        KIND_STOP,
        KIND_START,
        KIND_LOG,
        KIND_OFF
    } kind_t;

    // state of the line seen so far, before the current word
    typedef struct packed {
        logic                  overflow;
        logic [FORM_COUNT-1:0] alive;
        logic                  digits_only;
        logic [15:0]           number;
        logic [7:0]            length;
    } line_info_t;

    // one result word
    typedef struct packed {
        logic        line_done;
        kind_t       command_kind;
        logic        echo_line;
        logic        celsius_mode;
        logic [15:0] period_seconds;
        logic        reporting_on;
        logic        off_requested;
    } result_t;

endpackage

>>> sv/text_command_line_decoder.sv
// ----------------------------------------------------------------------------
// text_command_line_decoder
// Matches newline-terminated command lines in a received byte stream and
// keeps the scale, period, reporting and shutdown settings they select.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel rx_byte / byte_valid / byte_stall takes one received byte
//   per word. Output channel result_valid / result_stall returns exactly one
//   result word per byte: line_done, command_kind and echo_line describe the
//   line ended by a newline byte (all zero for other bytes), and the setting
//   fields show the settings after that byte.
//   A byte accepted into the input register is decoded combinationally and
//   its result is offered once it is loaded into the result register.
//   Throughput: one byte per cycle unless result_stall holds a waiting result,
//   set by the combinational decode between the input and result registers.
//   Stall: while result_stall holds a waiting result, one more byte is still
//   taken into the input register; byte_stall rises only when both the input
//   and the result register are full.
//   Reset: both registers empty, scale Fahrenheit, period 1 s, reporting on,
//   no shutdown request, line tracking at the start of a line.
// ----------------------------------------------------------------------------
module text_command_line_decoder
    import tcld_pkg::*;
#(
    parameter int LINE_MAX   = 128,
    parameter int PERIOD_MAX = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  logic        byte_valid,
    output logic        byte_stall,
    output logic        line_done,
    output logic [2:0]  command_kind,
    output logic        echo_line,
    output logic        celsius_mode,
    output logic [15:0] period_seconds,
    output logic        reporting_on,
    output logic        off_requested,
    output logic        result_valid,
    input  logic        result_stall
);

    logic    in_valid_reg,  in_valid_next;
    char_t   in_byte_reg;
    logic    out_valid_reg, out_valid_next;
    result_t res_reg;

    logic       accept;
    logic       advance;
    line_info_t info;
    result_t    res_comb;

    // handshake control
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall = in_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input and result payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    // line tracking
    tcld_line #(
        .LINE_MAX   (LINE_MAX),
        .PERIOD_MAX (PERIOD_MAX)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .info    (info)
    );

    // command execution
    tcld_exec u_exec (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .info    (info),
        .res     (res_comb)
    );

    assign result_valid   = out_valid_reg;
    assign line_done      = res_reg.line_done;
    assign command_kind   = res_reg.command_kind;
    assign echo_line      = res_reg.echo_line;
    assign celsius_mode   = res_reg.celsius_mode;
    assign period_seconds = res_reg.period_seconds;
    assign reporting_on   = res_reg.reporting_on;
    assign off_requested  = res_reg.off_requested;

endmodule

>>> sv/tcld_line.sv
// ----------------------------------------------------------------------------
// tcld_line
// Per-line tracker: narrows the set of command forms still matching, counts
// characters and bytes, and accumulates the period digits.
// ----------------------------------------------------------------------------
module tcld_line
    import tcld_pkg::*;
#(
    parameter int LINE_MAX   = 128,
    parameter int PERIOD_MAX = 65535
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  char_t      rx_byte,
    output line_info_t info
);

    localparam int                LB_W      = $clog2(LINE_MAX + 1);
    localparam logic [LB_W-1:0]   LB_LIMIT  = LB_W'(LINE_MAX);
    localparam logic [19:0]       NUM_LIMIT = 20'(PERIOD_MAX);
    localparam logic [15:0]       NUM_SAT   = 16'(PERIOD_MAX);

    logic [7:0]            pos_reg,      pos_next;
    logic [FORM_COUNT-1:0] alive_reg,    alive_next;
    logic                  ended_reg,    ended_next;
    logic                  overflow_reg, overflow_next;
    logic                  digits_reg,   digits_next;
    logic [15:0]           number_reg,   number_next;
    logic [LB_W-1:0]       bytes_reg,    bytes_next;

    logic [19:0] num_wide;
    logic [19:0] num_scaled;
    logic        is_digit;

    // decimal accumulate: number * 10 + digit
    assign num_wide   = {4'b0, number_reg};
    assign num_scaled = (num_wide << 3) + (num_wide << 1) + {16'b0, rx_byte[3:0]};
    assign is_digit   = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);

    // next line state for the current word
    always_comb
    begin
        pos_next      = pos_reg;
        alive_next    = alive_reg;
        ended_next    = ended_reg;
        overflow_next = overflow_reg;
        digits_next   = digits_reg;
        number_next   = number_reg;
        bytes_next    = bytes_reg;
        if (rx_byte == CHAR_NL)
        begin
            pos_next      = 8'd0;
            alive_next    = '1;
            ended_next    = 1'b0;
            overflow_next = 1'b0;
            digits_next   = 1'b1;
            number_next   = 16'd0;
            bytes_next    = '0;
        end
        else
        begin
            if (bytes_reg != LB_LIMIT)
            begin
                bytes_next = bytes_reg + 1'b1;
            end
            if (bytes_next == LB_LIMIT)
            begin
                overflow_next = 1'b1;
            end
            if (!ended_reg)
            begin
                if (rx_byte == CHAR_NUL)
                begin
                    ended_next = 1'b1;
                end
                else
                begin
                    // drop forms that this character rules out
                    for (int k = 0; k < FORM_COUNT; k++)
                    begin
                        if ({4'b0, FORM_LEN[k]} > pos_reg)
                        begin
                            if (rx_byte != FORM_TEXT[k][pos_reg[2:0]])
                            begin
                                alive_next[k] = 1'b0;
                            end
                        end
                        else if (FORM_EXACT[k])
                        begin
                            alive_next[k] = 1'b0;
                        end
                    end
                    // period digits after the prefix
                    if (pos_reg >= 8'(PREFIX_LEN))
                    begin
                        if (is_digit)
                        begin
                            number_next = (num_scaled > NUM_LIMIT) ? NUM_SAT
                                                                   : num_scaled[15:0];
                        end
                        else
                        begin
                            digits_next = 1'b0;
                        end
                    end
                    if (pos_reg != 8'hFF)
                    begin
                        pos_next = pos_reg + 8'd1;
                    end
                end
            end
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 8'd0;
            alive_reg    <= '1;
            ended_reg    <= 1'b0;
            overflow_reg <= 1'b0;
            digits_reg   <= 1'b1;
            number_reg   <= 16'd0;
            bytes_reg    <= '0;
        end
        else if (step)
        begin
            pos_reg      <= pos_next;
            alive_reg    <= alive_next;
            ended_reg    <= ended_next;
            overflow_reg <= overflow_next;
            digits_reg   <= digits_next;
            number_reg   <= number_next;
            bytes_reg    <= bytes_next;
        end
    end

    assign info.overflow    = overflow_reg;
    assign info.alive       = alive_reg;
    assign info.digits_only = digits_reg;
    assign info.number      = number_reg;
    assign info.length      = pos_reg;

endmodule

>>> sv/tcld_exec.sv
// ----------------------------------------------------------------------------
// tcld_exec
// Command execution: at a newline picks the first form that still matches,
// applies it to the scale, period, reporting and off settings, and builds
// the result word.
// ----------------------------------------------------------------------------
module tcld_exec
    import tcld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  char_t      rx_byte,
    input  line_info_t info,
    output result_t    res
);

    logic        scale_reg,  scale_next;
    logic [15:0] period_reg, period_next;
    logic        report_reg, report_next;
    logic        off_reg,    off_next;

    logic [FORM_COUNT-1:0] matched;
    form_idx_t             sel;
    logic                  is_nl;
    kind_t                 kind;
    logic                  echo;

    assign is_nl = (rx_byte == CHAR_NL);

    // forms still alive and fully present in the line; lowest one wins
    always_comb
    begin
        sel = FORM_SCALE_F;
        for (int k = 0; k < FORM_COUNT; k++)
        begin
            matched[k] = info.alive[k] && ({4'b0, FORM_LEN[k]} <= info.length);
        end
        for (int k = FORM_COUNT - 1; k >= 0; k--)
        begin
            if (matched[k])
            begin
                sel = form_idx_t'(k);
            end
        end
    end

    // apply the command at the end of the line
    always_comb
    begin
        scale_next  = scale_reg;
        period_next = period_reg;
        report_next = report_reg;
        off_next    = off_reg;
        kind        = KIND_NONE;
        echo        = 1'b0;
        if (is_nl && !info.overflow && (|matched))
        begin
            echo = 1'b1;
            case (sel)
                FORM_SCALE_F:
                begin
                    kind       = KIND_SCALE_F;
                    scale_next = 1'b0;
                end
                FORM_SCALE_C:
                begin
                    kind       = KIND_SCALE_C;
                    scale_next = 1'b1;
                end
                FORM_PERIOD:
                begin
                    kind = KIND_PERIOD;
                    if ((info.length > 8'(PREFIX_LEN)) && info.digits_only)
                    begin
                        period_next = (info.number == 16'd0) ? 16'd1 : info.number;
                    end
                end
                FORM_STOP:
                begin
                    kind        = KIND_STOP;
                    report_next = 1'b0;
                end
                FORM_START:
                begin
                    kind        = KIND_START;
                    report_next = 1'b1;
                end
                FORM_LOG:
                begin
                    kind = KIND_LOG;
                end
                FORM_OFF:
                begin
                    kind     = KIND_OFF;
                    off_next = 1'b1;
                end
                default:
                begin
                    kind = KIND_NONE;
                    echo = 1'b0;
                end
            endcase
        end
    end

    // settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= 1'b0;
            period_reg <= 16'd1;
            report_reg <= 1'b1;
            off_reg    <= 1'b0;
        end
        else if (step)
        begin
            scale_reg  <= scale_next;
            period_reg <= period_next;
            report_reg <= report_next;
            off_reg    <= off_next;
        end
    end

    assign res.line_done      = is_nl;
    assign res.command_kind   = kind;
    assign res.echo_line      = echo;
    assign res.celsius_mode   = scale_next;
    assign res.period_seconds = period_next;
    assign res.reporting_on   = report_next;
    assign res.off_requested  = off_next;

endmodule

>>> sv/tcld_checker.sv
// ----------------------------------------------------------------------------
// tcld_checker
// Port-level checks on the result words of the text command line decoder,
// attached to the top level by a bind.
// ----------------------------------------------------------------------------
`include "text_command_line_decoder_assert.svh"

module tcld_checker
    import tcld_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        line_done,
    input logic [2:0]  command_kind,
    input logic        echo_line,
    input logic [15:0] period_seconds,
    input logic        off_requested,
    input logic        result_valid,
    input logic        result_stall
);

    logic mid_line;
    logic word_taken;

    assign mid_line   = result_valid && !line_done;
    assign word_taken = result_valid && !result_stall;

    // a byte that is not a newline carries no command
    `TCLD_ASSERT_SAME(a_no_cmd_mid_line, mid_line, command_kind == KIND_NONE && !echo_line)

    // an echoed line always names a command
    `TCLD_ASSERT_SAME(a_echo_has_kind, result_valid && echo_line, command_kind != KIND_NONE)

    // the period never reads zero
    `TCLD_ASSERT_SAME(a_period_nonzero, result_valid, period_seconds != 16'd0)

    // the shutdown request is sticky across delivered results
    `TCLD_ASSERT_NEXT(a_off_sticky, word_taken && off_requested, !result_valid || off_requested)

endmodule

bind text_command_line_decoder tcld_checker u_tcld_checker (.*);
